// ===== rtl/core/tagged_int64_alu_core_macros.svh =====
// assertion macros for the tagged 64-bit alu core
// expects clk and arst_n in the scope of the module that uses them
`ifndef TAGGED_INT64_ALU_CORE_MACROS_SVH
`define TAGGED_INT64_ALU_CORE_MACROS_SVH

// same-cycle implication
`define TIA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define TIA_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tia_pkg.sv =====
// shared types, widths and operation codes of the tagged 64-bit alu core
// no dependencies
`default_nettype none

package tia_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;
	localparam int unsigned PROD_W = 2 * WORD_W;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_NEG = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic signed [WORD_W:0] ext_t;
	typedef logic [WORD_W+1:0] sum_t;

	localparam word_t TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct packed {
		logic a_sg;
		logic b_sg;
		logic a_neg;
		logic b_neg;
		logic a_zero;
		logic b_zero;
	} oper_flags_t;

	typedef struct packed {
		word_t value;
		logic  is_signed;
		logic  ovf;
		logic  lt;
		logic  eq;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/tia_mul.sv =====
// pipelined 64x64 unsigned multiplier built from four 32x32 partial products
// three register stages; depends on tia_pkg
`default_nettype none

module tia_mul
	import tia_pkg::*;
(
	input  wire   clk,
	input  word_t mag_a,
	input  word_t mag_b,
	output prod_t prod
);

	logic [WORD_W-1:0] pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [WORD_W:0]   mid_s3;
	logic [WORD_W-1:0] ll_s3, hh_s3;
	prod_t             p_s4;

	// partial products
	always_ff @(posedge clk) begin
		pp_ll_s2 <= mag_a[HALF_W-1:0] * mag_b[HALF_W-1:0];
		pp_lh_s2 <= mag_a[HALF_W-1:0] * mag_b[WORD_W-1:HALF_W];
		pp_hl_s2 <= mag_a[WORD_W-1:HALF_W] * mag_b[HALF_W-1:0];
		pp_hh_s2 <= mag_a[WORD_W-1:HALF_W] * mag_b[WORD_W-1:HALF_W];
	end

	// cross terms
	always_ff @(posedge clk) begin
		mid_s3 <= {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};
		ll_s3  <= pp_ll_s2;
		hh_s3  <= pp_hh_s2;
	end

	// final sum
	always_ff @(posedge clk) begin
		p_s4 <= {hh_s3, ll_s3} + {{(HALF_W-1){1'b0}}, mid_s3, {HALF_W{1'b0}}};
	end

	assign prod = p_s4;

endmodule

`default_nettype wire

// ===== rtl/core/tagged_int64_alu_core.sv =====
// tagged 64-bit alu core: add, subtract, multiply, negate, compare on tagged words
// done rises for one cycle, registered in the same cycle as the result, which is valid while done is high
// throughput: one transaction per cycle, busy stays low; five register stages,
// the depth set by the partial-product multiplier (tia_mul)
// reset: arst_n clears the valid chain at once; no transaction is lost to a stall
`default_nettype none
`include "tagged_int64_alu_core_macros.svh"

module tagged_int64_alu_core
	import tia_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire [2:0]         req_type,
	input  wire [WORD_W-1:0]  a_value,
	input  wire               a_is_signed,
	input  wire [WORD_W-1:0]  b_value,
	input  wire               b_is_signed,
	output logic              done,
	output logic [WORD_W-1:0] res_value,
	output logic              res_is_signed,
	output logic              overflow,
	output logic              less,
	output logic              equal
);

	logic accept;
	logic a_neg_c, b_neg_c;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [2:0]  op_s1, op_s2;
	ext_t        a_x_s1, b_x_s1;
	word_t       mag_a_s1, mag_b_s1;
	oper_flags_t fl_s1, fl_s2;
	sum_t        sum_s2;
	logic        lt_s2, eq_s2;
	logic        mul_s3, mul_s4;
	logic        ns_s3, ns_s4;
	res_t        res_s3, res_s4;
	prod_t       prod_s4;

	ext_t  lhs_c, rhs_c;
	sum_t  sum_c;
	logic  in_range_c, nonpos_c;
	res_t  res_c;
	logic  hi_zero_c;
	word_t lo_c;
	res_t  out_c;

	logic done_q;
	res_t res_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// stage 1: operand decode and magnitudes
	assign a_neg_c = a_is_signed & a_value[WORD_W-1];
	assign b_neg_c = b_is_signed & b_value[WORD_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s1         <= req_type;
		a_x_s1        <= {a_neg_c, a_value};
		b_x_s1        <= {b_neg_c, b_value};
		mag_a_s1      <= a_neg_c ? (word_t'(0) - a_value) : a_value;
		mag_b_s1      <= b_neg_c ? (word_t'(0) - b_value) : b_value;
		fl_s1.a_sg    <= a_is_signed;
		fl_s1.b_sg    <= b_is_signed;
		fl_s1.a_neg   <= a_neg_c;
		fl_s1.b_neg   <= b_neg_c;
		fl_s1.a_zero  <= (a_value == '0);
		fl_s1.b_zero  <= (b_value == '0);
	end

	tia_mul u_mul (
		.clk   (clk),
		.mag_a (mag_a_s1),
		.mag_b (mag_b_s1),
		.prod  (prod_s4)
	);

	// stage 2: wide add or subtract, compare
	always_comb begin
		lhs_c = a_x_s1;
		rhs_c = b_x_s1;
		if (op_s1 == OP_NEG) begin
			lhs_c = '0;
			rhs_c = a_x_s1;
		end
		if (op_s1 == OP_ADD) begin
			sum_c = {lhs_c[WORD_W], lhs_c} + {rhs_c[WORD_W], rhs_c};
		end else begin
			sum_c = {lhs_c[WORD_W], lhs_c} - {rhs_c[WORD_W], rhs_c};
		end
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		fl_s2  <= fl_s1;
		sum_s2 <= sum_c;
		lt_s2  <= (a_x_s1 < b_x_s1);
		eq_s2  <= (a_x_s1 == b_x_s1);
	end

	// stage 3: range check and tag rules
	assign in_range_c = (sum_s2[WORD_W+1:WORD_W] == 2'b00) ||
		(sum_s2[WORD_W+1:WORD_W-1] == 3'b111);
	assign nonpos_c = sum_s2[WORD_W+1] || (sum_s2 == '0);

	always_comb begin
		res_c = '0;
		unique case (op_s2)
			OP_ADD: begin
				res_c.value = sum_s2[WORD_W-1:0];
				if (fl_s2.a_sg && fl_s2.b_sg) begin
					res_c.is_signed = fl_s2.a_neg | fl_s2.b_neg | fl_s2.a_zero | fl_s2.b_zero;
				end else begin
					res_c.is_signed = (fl_s2.a_neg | fl_s2.b_neg) & nonpos_c;
				end
			end
			OP_SUB: begin
				res_c.value     = sum_s2[WORD_W-1:0];
				res_c.is_signed = nonpos_c;
			end
			OP_NEG: begin
				res_c.value     = sum_s2[WORD_W-1:0];
				res_c.is_signed = fl_s2.a_sg ? (~fl_s2.a_neg & ~fl_s2.a_zero) : 1'b1;
			end
			OP_CMP: begin
				res_c.lt = lt_s2;
				res_c.eq = eq_s2;
			end
			default: begin
				res_c = '0;
			end
		endcase
		if ((op_s2 == OP_ADD || op_s2 == OP_SUB || op_s2 == OP_NEG) && !in_range_c) begin
			res_c.value     = '0;
			res_c.is_signed = 1'b0;
			res_c.ovf       = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s3 <= (op_s2 == OP_MUL);
		ns_s3  <= fl_s2.a_neg ^ fl_s2.b_neg;
		res_s3 <= res_c;
	end

	// stage 4: wait for the product
	always_ff @(posedge clk) begin
		mul_s4 <= mul_s3;
		ns_s4  <= ns_s3;
		res_s4 <= res_s3;
	end

	// stage 5: product range check and sign
	assign hi_zero_c = (prod_s4[PROD_W-1:WORD_W] == '0);
	assign lo_c      = prod_s4[WORD_W-1:0];

	always_comb begin
		out_c = res_s4;
		if (mul_s4) begin
			out_c = '0;
			if (ns_s4) begin
				if (hi_zero_c && lo_c <= TOP_BIT) begin
					out_c.value     = word_t'(0) - lo_c;
					out_c.is_signed = 1'b1;
				end else begin
					out_c.ovf = 1'b1;
				end
			end else if (hi_zero_c) begin
				out_c.value = lo_c;
			end else begin
				out_c.ovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= out_c;
	end

	assign done          = done_q;
	assign res_value     = res_q.value;
	assign res_is_signed = res_q.is_signed;
	assign overflow      = res_q.ovf;
	assign less          = res_q.lt;
	assign equal         = res_q.eq;

	`TIA_ASSERT_IMP(a_ovf_clear, done && overflow, res_value == '0 && !res_is_signed, "overflow result not cleared")
	`TIA_ASSERT_IMP(a_cmp_excl, done, !(less && equal), "less and equal both set")
	`TIA_ASSERT_IMP(a_cmp_only, done && (less || equal), res_value == '0 && !res_is_signed && !overflow, "compare flags on arithmetic result")
	`TIA_ASSERT_DLY(a_latency, start && !busy, 5, done, "accepted transaction produced no result")
	`TIA_ASSERT_IMP(a_no_spurious, done, $past(start, 5), "result without accepted transaction")

endmodule

`default_nettype wire

// ===== tb/tagged_int64_alu_core_test.sv =====
// self-checking testbench for tagged_int64_alu_core: directed corner cases per operation,
// then a long random mix, every result checked against a behavioral predictor in order
// depends on tia_pkg and the tagged_int64_alu_core rtl
`default_nettype none

module tagged_int64_alu_core_test;
	import tia_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 10;
	localparam int RANDOM_ITEMS    = 1800;
	localparam int DRAIN_LIMIT     = 200;
	localparam int TAIL_CYCLES     = 16;
	localparam int WATCHDOG_CYCLES = 400000;
	localparam int MAX_REPORTS     = 10;

	localparam logic [2:0] OP_RSVD_LAST = 3'd7;

	localparam logic SG = 1'b1;
	localparam logic UN = 1'b0;

	localparam word_t WORD_MAX   = '1;
	localparam word_t SIGNED_MAX = ~TOP_BIT;

	typedef struct packed {
		word_t v;
		logic  s;
		logic  o;
	} tagged_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	word_t       a_value;
	logic        a_is_signed;
	word_t       b_value;
	logic        b_is_signed;
	logic        done;
	word_t       res_value;
	logic        res_is_signed;
	logic        overflow;
	logic        less;
	logic        equal;

	res_t pending_alu_results[$];
	int   op_count [8];
	int   error_count;
	int   checked_count;
	int   overflow_count;
	bit   no_idle;

	tagged_int64_alu_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.a_value      (a_value),
		.a_is_signed  (a_is_signed),
		.b_value      (b_value),
		.b_is_signed  (b_is_signed),
		.done         (done),
		.res_value    (res_value),
		.res_is_signed(res_is_signed),
		.overflow     (overflow),
		.less         (less),
		.equal        (equal)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("[tagged_int64_alu_core] ERROR");
		$finish;
	end

	function automatic tagged_word_t tw(input word_t v, input logic s, input logic o);
		tagged_word_t t;
		t.v = v;
		t.s = s;
		t.o = o;
		return t;
	endfunction

	function automatic logic tw_is_neg(input tagged_word_t x);
		return x.s && x.v[WORD_W-1];
	endfunction

	function automatic tagged_word_t negate_tw(input tagged_word_t x);
		if (x.s) begin
			if (x.v[WORD_W-1] || x.v == '0)
				return tw(-x.v, 1'b0, 1'b0);
			return tw(-x.v, 1'b1, 1'b0);
		end
		if (x.v > TOP_BIT)
			return tw('0, 1'b0, 1'b1);
		return tw(-x.v, 1'b1, 1'b0);
	endfunction

	// both operands non-negative
	function automatic tagged_word_t diff_nonneg(input tagged_word_t a, input tagged_word_t b);
		word_t r;
		if (a.v > b.v)
			return tw(a.v - b.v, 1'b0, 1'b0);
		r = b.v - a.v;
		if (r > TOP_BIT)
			return tw('0, 1'b0, 1'b1);
		return tw(-r, 1'b1, 1'b0);
	endfunction

	function automatic tagged_word_t sum_unsigned(input tagged_word_t a, input tagged_word_t b);
		logic [WORD_W:0] r;
		r = {1'b0, a.v} + {1'b0, b.v};
		if (r[WORD_W])
			return tw('0, 1'b0, 1'b1);
		return tw(r[WORD_W-1:0], 1'b0, 1'b0);
	endfunction

	function automatic tagged_word_t add_tw(input tagged_word_t a, input tagged_word_t b);
		logic            an;
		logic            bn;
		word_t           ua;
		word_t           ub;
		logic [WORD_W:0] ur;
		if (a.s == b.s) begin
			if (!a.s)
				return sum_unsigned(a, b);
			an = a.v[WORD_W-1];
			bn = b.v[WORD_W-1];
			if (((an || a.v == '0) && !bn) || ((bn || b.v == '0) && !an))
				return tw(a.v + b.v, 1'b1, 1'b0);
			if (!an && !bn)
				return sum_unsigned(a, b);
			if (a.v == TOP_BIT || b.v == TOP_BIT)
				return tw('0, 1'b0, 1'b1);
			ua = -a.v;
			ub = -b.v;
			ur = {1'b0, ua} + {1'b0, ub};
			if (ur > {1'b0, TOP_BIT})
				return tw('0, 1'b0, 1'b1);
			return tw(-ur[WORD_W-1:0], 1'b1, 1'b0);
		end
		if (tw_is_neg(a))
			return diff_nonneg(b, negate_tw(a));
		if (tw_is_neg(b))
			return diff_nonneg(a, negate_tw(b));
		return sum_unsigned(a, b);
	endfunction

	function automatic tagged_word_t sub_tw(input tagged_word_t a, input tagged_word_t b);
		if (!tw_is_neg(a) && !tw_is_neg(b))
			return diff_nonneg(a, b);
		if (tw_is_neg(b))
			return add_tw(a, negate_tw(b));
		if (b.v > a.v - TOP_BIT)
			return tw('0, 1'b0, 1'b1);
		return tw(a.v - b.v, 1'b1, 1'b0);
	endfunction

	function automatic tagged_word_t mul_tw(input tagged_word_t a, input tagged_word_t b);
		tagged_word_t x;
		tagged_word_t y;
		tagged_word_t n;
		tagged_word_t p;
		prod_t        pr;
		x = a;
		y = b;
		if (tw_is_neg(x) && tw_is_neg(y)) begin
			x = negate_tw(x);
			y = negate_tw(y);
		end
		if (!tw_is_neg(x) && !tw_is_neg(y)) begin
			pr = prod_t'(x.v) * prod_t'(y.v);
			if (pr[PROD_W-1:WORD_W] != '0)
				return tw('0, 1'b0, 1'b1);
			return tw(pr[WORD_W-1:0], 1'b0, 1'b0);
		end
		if (tw_is_neg(x)) begin
			n = x;
			p = y;
		end else begin
			n = y;
			p = x;
		end
		n = negate_tw(n);
		pr = prod_t'(n.v) * prod_t'(p.v);
		if (pr > prod_t'(TOP_BIT))
			return tw('0, 1'b0, 1'b1);
		return tw(-pr[WORD_W-1:0], 1'b1, 1'b0);
	endfunction

	function automatic logic less_tw(input tagged_word_t a, input tagged_word_t b);
		if (a.s == b.s) begin
			if (!a.s)
				return a.v < b.v;
			return (a.v ^ TOP_BIT) < (b.v ^ TOP_BIT);
		end
		if (tw_is_neg(a))
			return 1'b1;
		if (tw_is_neg(b))
			return 1'b0;
		return a.v < b.v;
	endfunction

	function automatic res_t alu_predict(input logic [2:0] op, input word_t a, input logic a_sg,
			input word_t b, input logic b_sg);
		tagged_word_t x;
		tagged_word_t y;
		tagged_word_t r;
		res_t         e;
		x = tw(a, a_sg, 1'b0);
		y = tw(b, b_sg, 1'b0);
		r = tw('0, 1'b0, 1'b0);
		e = '0;
		case (op)
			OP_ADD: r = add_tw(x, y);
			OP_SUB: r = sub_tw(x, y);
			OP_MUL: r = mul_tw(x, y);
			OP_NEG: r = negate_tw(x);
			OP_CMP: begin
				e.lt = less_tw(x, y);
				e.eq = !less_tw(x, y) && !less_tw(y, x);
			end
			default: ;
		endcase
		if (!r.o) begin
			e.value     = r.v;
			e.is_signed = r.s;
		end
		e.ovf = r.o;
		return e;
	endfunction

	function automatic void flag_error(input string msg);
		if (error_count < MAX_REPORTS)
			$display("%s", msg);
		error_count++;
	endfunction

	function automatic word_t draw_operand();
		word_t w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = TOP_BIT + word_t'($urandom_range(0, 2)) - word_t'(1);
			3: w = word_t'($urandom_range(0, 255));
			4: w = -word_t'($urandom_range(0, 255));
			5: w = word_t'($urandom);
			6: w = w >> $urandom_range(0, 63);
			7: w = -(w >> $urandom_range(1, 63));
			default: ;
		endcase
		return w;
	endfunction

	// start stays high across back-to-back transactions
	task automatic issue_op(input logic [2:0] op, input word_t a, input logic a_sg,
			input word_t b, input logic b_sg);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type    <= op;
		a_value     <= a;
		a_is_signed <= a_sg;
		b_value     <= b;
		b_is_signed <= b_sg;
		start       <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_alu_results.push_back(alu_predict(op, a, a_sg, b, b_sg));
		op_count[op]++;
	endtask

	task automatic wait_results_drained();
		int guard;
		guard = 0;
		@(negedge clk);
		start <= 1'b0;
		while (pending_alu_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic test_add();
		issue_op(OP_ADD, WORD_MAX, UN, 64'd1, UN);
		issue_op(OP_ADD, WORD_MAX, SG, 64'd1, SG);
		issue_op(OP_ADD, TOP_BIT, SG, WORD_MAX, SG);
		issue_op(OP_ADD, SIGNED_MAX, SG, SIGNED_MAX, SG);
		issue_op(OP_ADD, TOP_BIT, SG, WORD_MAX, UN);
		wait_results_drained();
	endtask

	task automatic test_sub();
		issue_op(OP_SUB, 64'd5, UN, 64'd5, UN);
		issue_op(OP_SUB, '0, UN, WORD_MAX, UN);
		issue_op(OP_SUB, '0, UN, TOP_BIT, UN);
		issue_op(OP_SUB, TOP_BIT, SG, 64'd1, UN);
		wait_results_drained();
	endtask

	task automatic test_mul();
		issue_op(OP_MUL, TOP_BIT, SG, WORD_MAX, SG);
		issue_op(OP_MUL, TOP_BIT, SG, TOP_BIT, SG);
		issue_op(OP_MUL, WORD_MAX, UN, WORD_MAX, UN);
		issue_op(OP_MUL, WORD_MAX, SG, TOP_BIT, UN);
		issue_op(OP_MUL, '0, UN, 64'hFFFF_FFFF_FFFF_FFFB, SG);
		wait_results_drained();
	endtask

	// b is ignored by negate, so it carries noise
	task automatic test_neg();
		issue_op(OP_NEG, TOP_BIT, SG, draw_operand(), 1'($urandom_range(0, 1)));
		issue_op(OP_NEG, 64'd5, SG, draw_operand(), 1'($urandom_range(0, 1)));
		issue_op(OP_NEG, '0, SG, draw_operand(), 1'($urandom_range(0, 1)));
		issue_op(OP_NEG, TOP_BIT, UN, draw_operand(), 1'($urandom_range(0, 1)));
		issue_op(OP_NEG, TOP_BIT + 64'd1, UN, draw_operand(), 1'($urandom_range(0, 1)));
		issue_op(OP_NEG, WORD_MAX, SG, draw_operand(), 1'($urandom_range(0, 1)));
		wait_results_drained();
	endtask

	task automatic test_cmp();
		issue_op(OP_CMP, WORD_MAX, SG, WORD_MAX, UN);
		issue_op(OP_CMP, TOP_BIT, SG, SIGNED_MAX, SG);
		issue_op(OP_CMP, 64'd7, SG, 64'd7, UN);
		issue_op(OP_CMP, WORD_MAX, UN, TOP_BIT, SG);
		wait_results_drained();
	endtask

	task automatic test_unknown_ops();
		for (int k = OP_CMP + 1; k <= OP_RSVD_LAST; k++)
			issue_op(3'(k), draw_operand(), 1'($urandom_range(0, 1)), draw_operand(),
				1'($urandom_range(0, 1)));
		wait_results_drained();
	endtask

	task automatic test_random_mix();
		int         valid_issued;
		logic [2:0] op;
		word_t      a;
		word_t      b;
		logic       a_sg;
		logic       b_sg;
		valid_issued = 0;
		while (valid_issued < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 399) == 0)
				wait_results_drained();
			if ($urandom_range(0, 19) == 0) begin
				op = 3'($urandom_range(OP_CMP + 1, OP_RSVD_LAST));
			end else begin
				op = 3'($urandom_range(OP_ADD, OP_CMP));
				valid_issued++;
			end
			a    = draw_operand();
			b    = ($urandom_range(0, 7) == 0) ? a : draw_operand();
			a_sg = 1'($urandom_range(0, 1));
			b_sg = 1'($urandom_range(0, 1));
			issue_op(op, a, a_sg, b, b_sg);
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && done) begin
			got.value     = res_value;
			got.is_signed = res_is_signed;
			got.ovf       = overflow;
			got.lt        = less;
			got.eq        = equal;
			if (pending_alu_results.size() == 0) begin
				flag_error($sformatf("unexpected result: value %h signed %b ovf %b less %b equal %b",
					got.value, got.is_signed, got.ovf, got.lt, got.eq));
			end else begin
				want = pending_alu_results.pop_front();
				checked_count++;
				if (want.ovf)
					overflow_count++;
				if (got !== want)
					flag_error($sformatf({"mismatch: expected value %h signed %b ovf %b less %b",
						" equal %b, got value %h signed %b ovf %b less %b equal %b"},
						want.value, want.is_signed, want.ovf, want.lt, want.eq,
						got.value, got.is_signed, got.ovf, got.lt, got.eq));
			end
		end
	end

	initial begin
		int unused_ops;
		arst_n         = 1'b0;
		start          = 1'b0;
		req_type       = OP_ADD;
		a_value        = '0;
		a_is_signed    = 1'b0;
		b_value        = '0;
		b_is_signed    = 1'b0;
		no_idle        = 1'b0;
		error_count    = 0;
		checked_count  = 0;
		overflow_count = 0;
		foreach (op_count[k])
			op_count[k] = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_add();
		test_sub();
		test_mul();
		test_neg();
		test_cmp();
		test_unknown_ops();
		test_random_mix();

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_alu_results.size() != 0)
			flag_error($sformatf("%0d transactions never produced a result",
				pending_alu_results.size()));

		unused_ops = 0;
		for (int k = OP_CMP + 1; k <= OP_RSVD_LAST; k++)
			unused_ops += op_count[k];
		$display("sent add %0d, sub %0d, mul %0d, neg %0d, cmp %0d, unused codes %0d",
			op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_NEG],
			op_count[OP_CMP], unused_ops);
		$display("checked %0d results, %0d overflowed, %0d errors",
			checked_count, overflow_count, error_count);
		if (error_count == 0)
			$display("[tagged_int64_alu_core] OK");
		else
			$display("[tagged_int64_alu_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tia_pkg.sv
rtl/core/tia_mul.sv
rtl/core/tagged_int64_alu_core.sv
tb/tagged_int64_alu_core_test.sv
